>>> hw/rtl/bhsc_pkg.sv
// Shared types, widths and commutation tables for the BLDC hall six-step commutator.
// Used by the top level and its checker; depends on nothing else.

package bhsc_pkg;

   localparam int DATA_W      = 32;
   localparam int DUTY_W      = 16;
   localparam int HALL_W      = 3;
   localparam int OP_W        = 2;
   localparam int MODE_W      = 2;
   localparam int PHASE_W     = 2;
   localparam int CSR_INDEX_W = 1;

   localparam int WINDOW    = 8;
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SEEN_W    = $clog2(WINDOW + 1);
   localparam int SUM_W     = DATA_W + SLOT_W;
   localparam int DIV_STEPS = SUM_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [DUTY_W-1:0] DUTY_RESET    = DUTY_W'(1000);
   localparam logic [DATA_W-1:0] RPM_NUM_RESET = DATA_W'(5000000);

   typedef enum logic [OP_W-1:0] {
      OP_FWD_KEY   = 2'd0,
      OP_REV_KEY   = 2'd1,
      OP_HALL_EDGE = 2'd2,
      OP_TIMEOUT   = 2'd3
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOP = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_REV  = 2'd2
   } mode_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_NONE = 2'd0,
      PH_U    = 2'd1,
      PH_V    = 2'd2,
      PH_W    = 2'd3
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DUTY    = 1'd0,
      CSR_RPM_NUM = 1'd1
   } csr_type;

   // Forward high side; the reverse low side uses the same table.
   function automatic phase_type fwd_high(input logic [HALL_W-1:0] hall);
      phase_type ph;
      case (hall)
         3'd1:    ph = PH_U;
         3'd2:    ph = PH_V;
         3'd3:    ph = PH_V;
         3'd4:    ph = PH_W;
         3'd5:    ph = PH_U;
         3'd6:    ph = PH_W;
         default: ph = PH_NONE;
      endcase
      return ph;
   endfunction

   // Forward low side; the reverse high side uses the same table.
   function automatic phase_type fwd_low(input logic [HALL_W-1:0] hall);
      phase_type ph;
      case (hall)
         3'd1:    ph = PH_W;
         3'd2:    ph = PH_U;
         3'd3:    ph = PH_W;
         3'd4:    ph = PH_V;
         3'd5:    ph = PH_V;
         3'd6:    ph = PH_U;
         default: ph = PH_NONE;
      endcase
      return ph;
   endfunction

endpackage

>>> hw/rtl/bldc_hall_six_step_commutator_unit.sv
// Top level of the BLDC hall six-step commutator with moving-average speed.
// Uses bhsc_pkg; holds the sequencer, the shared restoring divider and the sample window.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  operation, hall state, elapsed time
//   rsp      out        rsp_valid/rsp_stall  run state, gates, phases, compare, speed
//   csr      in         csr_write            index, write data
//
// Key events and hall edges with zero elapsed time go straight to the result state.
// A timeout runs only the average divide, a hall edge both: each divide is one bit a cycle
// through the single 35-bit restoring divider, first the speed sample, then the average.
// Reset is synchronous and clears control state, the window and the registers to defaults.
// A stalled result waits in the output register; the next word is taken meanwhile.

module bldc_hall_six_step_commutator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bhsc_pkg::OP_W-1:0]            req_operation,
   input  logic [bhsc_pkg::HALL_W-1:0]          req_hall_state,
   input  logic [bhsc_pkg::DATA_W-1:0]          req_elapsed_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bhsc_pkg::MODE_W-1:0]          rsp_run_state,
   output logic                                 rsp_gate_enable,
   output logic [bhsc_pkg::PHASE_W-1:0]         rsp_high_phase,
   output logic [bhsc_pkg::PHASE_W-1:0]         rsp_low_phase,
   output logic [bhsc_pkg::DUTY_W-1:0]          rsp_pwm_compare,
   output logic [bhsc_pkg::DATA_W-1:0]          rsp_speed_rpm,
   input  logic                                 csr_write,
   input  logic [bhsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bhsc_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int DATA_W = bhsc_pkg::DATA_W;
   localparam int SUM_W  = bhsc_pkg::SUM_W;
   localparam int SLOT_W = bhsc_pkg::SLOT_W;
   localparam int SEEN_W = bhsc_pkg::SEEN_W;
   localparam int CNT_W  = bhsc_pkg::CNT_W;
   localparam int WINDOW = bhsc_pkg::WINDOW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE_DIV,
      ST_PUSH,
      ST_AVG_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   bhsc_pkg::mode_type  mode_ff, mode_in, key_dir, comm_mode;
   bhsc_pkg::phase_type high_ff, high_in, low_ff, low_in, tbl_high, tbl_low;

   logic [bhsc_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic [DATA_W-1:0]           numer_ff, numer_in;

   logic [DATA_W-1:0] win_ff [WINDOW];
   logic              win_we;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DATA_W-1:0] avg_ff, avg_in;
   logic [DATA_W-1:0] sample_ff, sample_in;

   logic [DATA_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W+1:0] rem_diff;
   logic              div_ge;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bhsc_pkg::MODE_W-1:0]     rsp_mode_ff, rsp_mode_in;
   logic                            rsp_gate_ff, rsp_gate_in;
   logic [bhsc_pkg::PHASE_W-1:0]    rsp_high_ff, rsp_high_in;
   logic [bhsc_pkg::PHASE_W-1:0]    rsp_low_ff, rsp_low_in;
   logic [bhsc_pkg::DUTY_W-1:0]     rsp_cmp_ff, rsp_cmp_in;
   logic [DATA_W-1:0]               rsp_speed_ff, rsp_speed_in;

   logic req_take;
   logic out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign key_dir   = (req_operation == bhsc_pkg::OP_FWD_KEY) ? bhsc_pkg::MODE_FWD
                                                              : bhsc_pkg::MODE_REV;
   assign comm_mode = (req_operation == bhsc_pkg::OP_HALL_EDGE) ? mode_ff : key_dir;

   always_comb begin
      unique case (comm_mode)
         bhsc_pkg::MODE_FWD: begin
            tbl_high = bhsc_pkg::fwd_high(req_hall_state);
            tbl_low  = bhsc_pkg::fwd_low(req_hall_state);
         end
         bhsc_pkg::MODE_REV: begin
            tbl_high = bhsc_pkg::fwd_low(req_hall_state);
            tbl_low  = bhsc_pkg::fwd_high(req_hall_state);
         end
         default: begin
            tbl_high = bhsc_pkg::PH_NONE;
            tbl_low  = bhsc_pkg::PH_NONE;
         end
      endcase
   end

   assign rem_shift = {rem_ff[DATA_W-1:0], quo_ff[SUM_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, den_ff};
   assign div_ge    = !rem_diff[DATA_W+1];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      duty_in      = duty_ff;
      numer_in     = numer_ff;
      win_we       = 1'b0;
      slot_in      = slot_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      sample_in    = sample_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mode_in  = rsp_mode_ff;
      rsp_gate_in  = rsp_gate_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_speed_in = rsp_speed_ff;

      if (csr_write) begin
         unique case (bhsc_pkg::csr_type'(csr_index))
            bhsc_pkg::CSR_DUTY:    duty_in  = csr_wdata[bhsc_pkg::DUTY_W-1:0];
            bhsc_pkg::CSR_RPM_NUM: numer_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_take) begin
               unique case (bhsc_pkg::op_type'(req_operation)) inside
                  bhsc_pkg::OP_FWD_KEY, bhsc_pkg::OP_REV_KEY: begin
                     if (mode_ff == key_dir) begin
                        mode_in = bhsc_pkg::MODE_STOP;
                        high_in = bhsc_pkg::PH_NONE;
                        low_in  = bhsc_pkg::PH_NONE;
                     end else begin
                        mode_in = key_dir;
                        high_in = tbl_high;
                        low_in  = tbl_low;
                     end
                     state_in = ST_DONE;
                  end
                  bhsc_pkg::OP_HALL_EDGE: begin
                     high_in = tbl_high;
                     low_in  = tbl_low;
                     if (req_elapsed_us != '0) begin
                        rem_in   = '0;
                        quo_in   = SUM_W'(numer_ff);
                        den_in   = req_elapsed_us;
                        cnt_in   = CNT_W'(bhsc_pkg::DIV_STEPS);
                        state_in = ST_SAMPLE_DIV;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  bhsc_pkg::OP_TIMEOUT: begin
                     sample_in = '0;
                     state_in  = ST_PUSH;
                  end
                  default: ;
               endcase
            end
         end
         ST_SAMPLE_DIV, ST_AVG_DIV: begin
            if (cnt_ff != '0) begin
               rem_in = div_ge ? rem_diff[DATA_W:0] : rem_shift;
               quo_in = {quo_ff[SUM_W-2:0], div_ge};
               cnt_in = cnt_ff - 1'b1;
            end else if (state_ff == ST_SAMPLE_DIV) begin
               sample_in = quo_ff[DATA_W-1:0];
               state_in  = ST_PUSH;
            end else begin
               avg_in   = quo_ff[DATA_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_PUSH: begin
            win_we  = 1'b1;
            sum_in  = sum_ff - SUM_W'(win_ff[slot_ff]) + SUM_W'(sample_ff);
            slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            seen_in = (seen_ff < SEEN_W'(WINDOW)) ? seen_ff + 1'b1 : seen_ff;
            rem_in  = '0;
            quo_in  = sum_in;
            den_in  = DATA_W'(seen_in);
            cnt_in  = CNT_W'(bhsc_pkg::DIV_STEPS);
            state_in = ST_AVG_DIV;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mode_in  = mode_ff;
               rsp_gate_in  = (mode_ff != bhsc_pkg::MODE_STOP);
               rsp_high_in  = high_ff;
               rsp_low_in   = low_ff;
               rsp_cmp_in   = duty_ff;
               rsp_speed_in = avg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= bhsc_pkg::MODE_STOP;
         high_ff      <= bhsc_pkg::PH_NONE;
         low_ff       <= bhsc_pkg::PH_NONE;
         duty_ff      <= bhsc_pkg::DUTY_RESET;
         numer_ff     <= bhsc_pkg::RPM_NUM_RESET;
         slot_ff      <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         duty_ff      <= duty_in;
         numer_ff     <= numer_in;
         slot_ff      <= slot_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (win_we) begin
            win_ff[slot_ff] <= sample_ff;
         end
      end
      sample_ff    <= sample_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      den_ff       <= den_in;
      cnt_ff       <= cnt_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_gate_ff  <= rsp_gate_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_state   = rsp_mode_ff;
   assign rsp_gate_enable = rsp_gate_ff;
   assign rsp_high_phase  = rsp_high_ff;
   assign rsp_low_phase   = rsp_low_ff;
   assign rsp_pwm_compare = rsp_cmp_ff;
   assign rsp_speed_rpm   = rsp_speed_ff;

endmodule

>>> hw/rtl/bhsc_checker.sv
// Port-level checker for the BLDC hall six-step commutator, bound to its top level.
// Uses bhsc_pkg for widths and phase and mode codes.

module bhsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [bhsc_pkg::MODE_W-1:0]      rsp_run_state,
   input logic                             rsp_gate_enable,
   input logic [bhsc_pkg::PHASE_W-1:0]     rsp_high_phase,
   input logic [bhsc_pkg::PHASE_W-1:0]     rsp_low_phase,
   input logic [bhsc_pkg::DATA_W-1:0]      rsp_speed_rpm
);

   // The gate driver is enabled exactly when the motor runs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gate_enable == (rsp_run_state != bhsc_pkg::MODE_STOP)))
      else $error("gate enable disagrees with run state");

   // A stopped motor drives no phase.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_state == bhsc_pkg::MODE_STOP) |->
      (rsp_high_phase == bhsc_pkg::PH_NONE && rsp_low_phase == bhsc_pkg::PH_NONE))
      else $error("phase driven while stopped");

   // High and low side never switch the same phase, and the low side is on whenever the high side is.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_high_phase != bhsc_pkg::PH_NONE) |->
      (rsp_low_phase != rsp_high_phase && rsp_low_phase != bhsc_pkg::PH_NONE))
      else $error("shoot-through or half-driven commutation");

   // No result word appears in the cycle after reset.
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result word right after reset");

   // A stalled result word stays valid and holds its speed and run state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_speed_rpm)
      && $stable(rsp_run_state)))
      else $error("stalled result word changed");

endmodule

bind bldc_hall_six_step_commutator_unit bhsc_checker u_bhsc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_run_state   (rsp_run_state),
   .rsp_gate_enable (rsp_gate_enable),
   .rsp_high_phase  (rsp_high_phase),
   .rsp_low_phase   (rsp_low_phase),
   .rsp_speed_rpm   (rsp_speed_rpm)
);
